// File: rtl/tpce_pkg.sv
// ----------------------------------------------------------------------------
// tpce_pkg
// Shared types and fixed-point constants of the three-point curvature block.
// ----------------------------------------------------------------------------
package tpce_pkg;

	// Fixed-point formats
	localparam int COORD_FRAC = 10;
	localparam int CURV_FRAC  = 16;
	localparam int ROOT_FRAC  = 7;
	localparam int SQRT_SHIFT = 2 * ROOT_FRAC;
	localparam int QUOT_SHIFT = CURV_FRAC + COORD_FRAC + ROOT_FRAC;

	// Queue between front end and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int KIND_BITS   = 3;

	// What the back end has to do with one queued word
	typedef enum logic [KIND_BITS-1:0] {
		K_SHORT = 3'd0, // path shorter than three points
		K_HOLD  = 3'd1, // third point, not last: hold k[1]
		K_FIRST = 3'd2, // fourth point, not last: emit k[0] and k[1]
		K_MID   = 3'd3, // later point, not last: emit held value
		K_END3  = 3'd4, // last point of a three-point path
		K_END4  = 3'd5, // last point of a four-point path
		K_END   = 3'd6  // last point of a longer path
	} kind_t;

endpackage

// File: rtl/tpce_queue.sv
// ----------------------------------------------------------------------------
// tpce_queue
// Short register FIFO between the point classifier and the curvature engine.
// ----------------------------------------------------------------------------
module tpce_queue import tpce_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign rdata = mem_q[rp_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// File: rtl/tpce_front.sv
// ----------------------------------------------------------------------------
// tpce_front
// Accepts path points, keeps the two-point window, forms the differences
// and classifies each point for the curvature engine.
// ----------------------------------------------------------------------------
module tpce_front import tpce_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [COORD_BITS-1:0]           pos_x,
	input  logic signed [COORD_BITS-1:0]           pos_y,
	input  logic                                   last_point,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   full,
	output logic                                   push,
	output logic [KIND_BITS+6*(COORD_BITS+1)-1:0]  push_data
);

	localparam int M = COORD_BITS + 1;

	logic signed [COORD_BITS-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [2:0]                   cnt_q;   // points so far, saturates at 4
	logic                         accept;
	kind_t                        kind;
	logic                         needed;
	logic signed [M-1:0]          dx1, dy1, dx2, dy2, cx, cy;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	// Differences over the window
	assign dx1 = M'(x1_q) - M'(x0_q);
	assign dy1 = M'(y1_q) - M'(y0_q);
	assign dx2 = M'(pos_x) - M'(x1_q);
	assign dy2 = M'(pos_y) - M'(y1_q);
	assign cx  = M'(pos_x) - M'(x0_q);
	assign cy  = M'(pos_y) - M'(y0_q);

	// Classification
	always_comb begin
		kind   = K_MID;
		needed = 1'b1;
		if (last_point) begin
			case (cnt_q)
				3'd0, 3'd1: kind = K_SHORT;
				3'd2:       kind = K_END3;
				3'd3:       kind = K_END4;
				default:    kind = K_END;
			endcase
		end else begin
			case (cnt_q)
				3'd0, 3'd1: needed = 1'b0;
				3'd2:       kind = K_HOLD;
				3'd3:       kind = K_FIRST;
				default:    kind = K_MID;
			endcase
		end
	end

	assign push      = accept && needed;
	assign push_data = {kind, dx1, dy1, dx2, dy2, cx, cy};

	// Window and point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q  <= '0;
			x1_q  <= '0;
			y0_q  <= '0;
			y1_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last_point) begin
				x0_q  <= '0;
				x1_q  <= '0;
				y0_q  <= '0;
				y1_q  <= '0;
				cnt_q <= '0;
			end else begin
				x0_q <= x1_q;
				y0_q <= y1_q;
				x1_q <= pos_x;
				y1_q <= pos_y;
				if (cnt_q != 3'd4) cnt_q <= cnt_q + 3'd1;
			end
		end
	end

endmodule

// File: rtl/tpce_back.sv
// ----------------------------------------------------------------------------
// tpce_back
// Curvature engine: shared multiplier, bit-serial root, cube and divide,
// then extrapolation and in-order delivery of the result words.
// ----------------------------------------------------------------------------
module tpce_back import tpce_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int CURV_BITS  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [31:0]                            thr,
	input  logic                                   q_empty,
	input  logic [KIND_BITS+6*(COORD_BITS+1)-1:0]  q_data,
	output logic                                   pop,
	output logic signed [CURV_BITS-1:0]            curvature,
	output logic                                   last_result,
	output logic                                   too_short,
	output logic                                   out_valid,
	input  logic                                   out_stall
);

	localparam int M    = COORD_BITS + 1;
	localparam int PW   = 2 * M;
	localparam int SW   = 2 * M + 1;
	localparam int NW   = 2 * M + 1;
	localparam int TW   = SW + SQRT_SHIFT + 1;
	localparam int RB   = TW / 2;
	localparam int DW   = SW + RB;
	localparam int QB   = CURV_BITS - 1;
	localparam int NNW  = NW + QUOT_SHIFT;
	localparam int CW   = (NNW > DW + QB) ? NNW : DW + QB;
	localparam int MAXS = (RB > QB) ? RB : QB;
	localparam int STW  = $clog2(MAXS);
	localparam int CB   = CURV_BITS;

	localparam logic signed [CB-1:0] KMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] KMIN = {1'b1, {(CB-1){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL   = 9'b000000010,
		S_PREP  = 9'b000000100,
		S_SQRT  = 9'b000001000,
		S_CUBE  = 9'b000010000,
		S_CHECK = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_LOAD  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} bstate_t;

	function automatic logic [M-1:0] mag(input logic signed [M-1:0] v);
		mag = v[M-1] ? M'(-v) : M'(v);
	endfunction

	// 2*a - b, saturated
	function automatic logic signed [CB-1:0] sat2(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b);
		logic signed [CB+1:0] t;
		t = ((CB+2)'(a) <<< 1) - (CB+2)'(b);
		if (t > (CB+2)'(KMAX))      sat2 = KMAX;
		else if (t < (CB+2)'(KMIN)) sat2 = KMIN;
		else                        sat2 = CB'(t);
	endfunction

	// Queue head
	kind_t               kind;
	logic signed [M-1:0] dx1, dy1, dx2, dy2, cx, cy;
	assign {kind, dx1, dy1, dx2, dy2, cx, cy} = q_data;

	bstate_t              st_q;
	logic [1:0]           mcnt_q;
	logic [STW-1:0]       step_q;
	logic [PW-1:0]        p_q, q_q, sx_q, sy_q;
	logic [NW-1:0]        num_q;
	logic                 neg_q;
	logic [TW-1:0]        t_q;
	logic [RB+1:0]        srem_q;
	logic [RB-1:0]        root_q;
	logic [DW-1:0]        acc_q, mcand_q, drem_q;
	logic [CW-1:0]        nn_q;
	logic [QB-1:0]        quo_q;
	logic signed [CB-1:0] kn_q, a_q;
	logic signed [CB-1:0] res_q [4];
	logic [2:0]           n_q;
	logic [1:0]           idx_q;
	logic                 end_q, short_q;

	// Shared multiplier
	logic [M-1:0]  op_a, op_b;
	logic [PW-1:0] prod;
	always_comb begin
		case (mcnt_q)
			2'd0:    begin op_a = mag(dx2); op_b = mag(dy1); end
			2'd1:    begin op_a = mag(dy2); op_b = mag(dx1); end
			2'd2:    begin op_a = mag(cx);  op_b = mag(cx);  end
			default: begin op_a = mag(cy);  op_b = mag(cy);  end
		endcase
	end
	assign prod = PW'(op_a) * PW'(op_b);

	// Numerator and chord square
	logic          pn, qn, nneg;
	logic [NW-1:0] nmag;
	logic [SW-1:0] ssum;
	always_comb begin
		pn = dx2[M-1] ^ dy1[M-1];
		qn = !(dy2[M-1] ^ dx1[M-1]);
		if (pn == qn) begin
			nmag = NW'(p_q) + NW'(q_q);
			nneg = pn;
		end else if (p_q >= q_q) begin
			nmag = NW'(p_q) - NW'(q_q);
			nneg = pn;
		end else begin
			nmag = NW'(q_q) - NW'(p_q);
			nneg = qn;
		end
		ssum = SW'(sx_q) + SW'(sy_q);
	end

	// Root step
	logic [RB+3:0] srem2, strial;
	logic          sfit;
	assign srem2  = {srem_q, t_q[TW-1:TW-2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sfit   = (srem2 >= strial);

	// Threshold and overflow checks
	logic [CW-1:0] nn_w, dq_w;
	logic          below, ovf;
	assign nn_w  = CW'(num_q) << QUOT_SHIFT;
	assign dq_w  = CW'(acc_q) << QB;
	assign below = (acc_q[DW-1:ROOT_FRAC] <= (DW-ROOT_FRAC)'(thr));
	assign ovf   = (nn_w >= dq_w);

	// Divide step
	logic [DW:0]          drem2;
	logic                 dfit;
	logic [QB-1:0]        quo_n;
	logic signed [CB-1:0] qval;
	assign drem2 = {drem_q, nn_q[QB-1]};
	assign dfit  = (drem2 >= {1'b0, acc_q});
	assign quo_n = {quo_q[QB-2:0], dfit};
	assign qval  = neg_q ? -CB'(quo_n) : CB'(quo_n);

	// Result list for the current word
	logic signed [CB-1:0] ld_res [4];
	logic signed [CB-1:0] k0;
	logic [2:0]           ld_n;
	logic                 ld_end, ld_short;
	logic signed [CB-1:0] ld_a;
	always_comb begin
		k0       = sat2(kn_q, '0);
		ld_res   = '{default: '0};
		ld_n     = 3'd0;
		ld_end   = 1'b0;
		ld_short = 1'b0;
		ld_a     = kn_q;
		case (kind)
			K_SHORT: begin
				ld_n = 3'd1; ld_end = 1'b1; ld_short = 1'b1; ld_a = '0;
			end
			K_HOLD: ld_n = 3'd0;
			K_FIRST: begin
				ld_res[0] = sat2(a_q, kn_q); ld_res[1] = a_q; ld_n = 3'd2;
			end
			K_MID: begin
				ld_res[0] = a_q; ld_n = 3'd1;
			end
			K_END3: begin
				ld_res[0] = k0; ld_res[1] = kn_q; ld_res[2] = sat2(kn_q, k0);
				ld_n = 3'd3; ld_end = 1'b1; ld_a = '0;
			end
			K_END4: begin
				ld_res[0] = sat2(a_q, kn_q); ld_res[1] = a_q; ld_res[2] = kn_q;
				ld_res[3] = sat2(kn_q, a_q);
				ld_n = 3'd4; ld_end = 1'b1; ld_a = '0;
			end
			default: begin
				ld_res[0] = a_q; ld_res[1] = kn_q; ld_res[2] = sat2(kn_q, a_q);
				ld_n = 3'd3; ld_end = 1'b1; ld_a = '0;
			end
		endcase
	end

	// Output handshake
	logic can_out, emit_fire, emit_done;
	assign can_out   = !out_valid || !out_stall;
	assign emit_fire = (st_q == S_EMIT) && can_out;
	assign emit_done = emit_fire && ({1'b0, idx_q} == n_q - 3'd1);
	assign pop       = emit_done || ((st_q == S_LOAD) && (ld_n == 3'd0));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			mcnt_q    <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			a_q       <= '0;
			kn_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit_fire)      out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (!q_empty) begin
						mcnt_q <= '0;
						if (kind == K_SHORT) begin
							kn_q <= '0;
							st_q <= S_LOAD;
						end else begin
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) st_q <= S_PREP;
				end
				S_PREP: begin
					step_q <= '0;
					st_q   <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(RB - 1)) begin
						step_q <= '0;
						st_q   <= S_CUBE;
					end
				end
				S_CUBE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(RB - 1)) st_q <= S_CHECK;
				end
				S_CHECK: begin
					step_q <= '0;
					if (below) begin
						kn_q <= '0;
						st_q <= S_LOAD;
					end else if (ovf) begin
						kn_q <= neg_q ? KMIN : KMAX;
						st_q <= S_LOAD;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(QB - 1)) begin
						kn_q <= qval;
						st_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					a_q   <= ld_a;
					n_q   <= ld_n;
					idx_q <= '0;
					st_q  <= (ld_n == 3'd0) ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (emit_fire) begin
						idx_q <= idx_q + 2'd1;
						if (emit_done) st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (st_q == S_MUL) begin
			case (mcnt_q)
				2'd0:    p_q  <= prod;
				2'd1:    q_q  <= prod;
				2'd2:    sx_q <= prod;
				default: sy_q <= prod;
			endcase
		end
		if (st_q == S_PREP) begin
			num_q   <= nmag;
			neg_q   <= nneg;
			t_q     <= TW'(ssum) << SQRT_SHIFT;
			srem_q  <= '0;
			root_q  <= '0;
			acc_q   <= '0;
			mcand_q <= DW'(ssum);
		end
		if (st_q == S_SQRT) begin
			t_q    <= t_q << 2;
			srem_q <= sfit ? (RB+2)'(srem2 - strial) : (RB+2)'(srem2);
			root_q <= {root_q[RB-2:0], sfit};
		end
		if (st_q == S_CUBE) begin
			if (root_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			root_q  <= root_q >> 1;
		end
		if (st_q == S_CHECK) begin
			nn_q   <= nn_w;
			drem_q <= DW'(nn_w >> QB);
			quo_q  <= '0;
		end
		if (st_q == S_DIV) begin
			nn_q   <= nn_q << 1;
			drem_q <= dfit ? DW'(drem2 - {1'b0, acc_q}) : DW'(drem2);
			quo_q  <= quo_n;
		end
		if (st_q == S_LOAD) begin
			res_q   <= ld_res;
			end_q   <= ld_end;
			short_q <= ld_short;
		end
		if (emit_fire) begin
			curvature   <= res_q[idx_q];
			last_result <= end_q && ({1'b0, idx_q} == n_q - 3'd1);
			too_short   <= short_q;
		end
	end

endmodule

// File: rtl/three_point_curvature_estimator.sv
// ----------------------------------------------------------------------------
// three_point_curvature_estimator
// Streaming signed curvature of a path from a three-point window.
// ----------------------------------------------------------------------------
// Points enter one word per accepted cycle while the two-entry queue has room;
// the curvature engine behind it takes one queued point at a time. A point
// that needs a new curvature occupies the engine through the shared multiply,
// the bit-serial square root and cube, the threshold and overflow check and,
// where needed, the bit-serial divide, then one emit per result word; a
// too-short path goes straight to its single result word. Results come out in
// point order, up to three points late, through a registered output stage, and
// the threshold register is written through its own always-ready port.
module three_point_curvature_estimator import tpce_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int CURV_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [CURV_BITS-1:0]  curvature,
	output logic                         last_result,
	output logic                         too_short
);

	localparam int EW = KIND_BITS + 6 * (COORD_BITS + 1);

	logic [31:0]   thr_q;
	logic          push, pop, q_empty, q_full;
	logic [EW-1:0] push_data, q_data;

	// Threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        thr_q <= 32'd1;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	tpce_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.pos_x(pos_x), .pos_y(pos_y), .last_point(last_point),
		.in_valid(in_valid), .in_stall(in_stall),
		.full(q_full), .push(push), .push_data(push_data)
	);

	tpce_queue #(.WIDTH(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(push_data), .pop(pop),
		.rdata(q_data), .empty(q_empty), .full(q_full)
	);

	tpce_back #(.COORD_BITS(COORD_BITS), .CURV_BITS(CURV_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .thr(thr_q),
		.q_empty(q_empty), .q_data(q_data), .pop(pop),
		.curvature(curvature), .last_result(last_result), .too_short(too_short),
		.out_valid(out_valid), .out_stall(out_stall)
	);

	// Checks
	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_short |-> last_result)
		else $error("too_short word without last_result");

	a_short_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_short |-> curvature == '0)
		else $error("too_short word with nonzero curvature");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule
